[hw/rtl/hnt_pkg.sv]
// Shared types and constants of the hello neighbor table.
// Used by hnt_cell, hnt_ctrl and hello_neighbor_table; depends on nothing.
`timescale 1ns / 1ps

package hnt_pkg;

   localparam int ID_W       = 32;
   localparam int ADDR_W     = 32;
   localparam int IVL_W      = 16;
   localparam int MASK_W     = 32;
   localparam int ALIVE_W    = 8;
   localparam int IFACE_W    = 2;
   localparam int MASK_REGS  = 4;
   localparam int REMOVED_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // request tdata: iface_index, peer_id, neighbor_addr, hello_interval, hello_mask
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 8;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HELLO_INTERVAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_IF0       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_IF1       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_IF2       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_IF3       = 3'd5;

   localparam logic [IVL_W-1:0]   HELLO_INTERVAL_RST = 16'd5;
   localparam logic [ALIVE_W-1:0] TIMEOUT_RST        = 8'd15;

   // item kinds
   localparam logic KIND_HELLO = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef enum logic [2:0] {
      ST_REFRESHED    = 3'd0,
      ST_ADDED        = 3'd1,
      ST_BAD_INTERVAL = 3'd2,
      ST_BAD_MASK     = 3'd3,
      ST_FULL         = 3'd4,
      ST_TICK         = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_INSERT,
      S_REPLY
   } fsm_type;

   // one table entry, as held in a cell
   typedef struct packed {
      logic               valid;
      logic [ID_W-1:0]    node_id;
      logic [ADDR_W-1:0]  address;
      logic [ALIVE_W-1:0] alive;
   } entry_type;

   // one request item
   typedef struct packed {
      logic               kind;
      logic [IFACE_W-1:0] iface_index;
      logic [ID_W-1:0]    peer_id;
      logic [ADDR_W-1:0]  neighbor_addr;
      logic [IVL_W-1:0]   hello_interval;
      logic [MASK_W-1:0]  hello_mask;
   } item_type;

   // configuration registers
   typedef struct packed {
      logic [IVL_W-1:0]                  hello_interval;
      logic [ALIVE_W-1:0]                timeout;
      logic [MASK_REGS-1:0][MASK_W-1:0]  mask;
   } cfg_type;

   // result of one item
   typedef struct packed {
      status_type           status;
      logic [REMOVED_W-1:0] removed_count;
   } result_type;

endpackage

[hw/rtl/hnt_cell.sv]
// One storage cell of the rotating neighbor ring: holds a single entry.
// Depends on hnt_pkg for entry_type.
`timescale 1ns / 1ps

module hnt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  hnt_pkg::entry_type entry_in,
   output hnt_pkg::entry_type entry_out
);
   import hnt_pkg::*;

   logic valid_ff;
   logic [ID_W-1:0]    node_id_ff;
   logic [ADDR_W-1:0]  address_ff;
   logic [ALIVE_W-1:0] alive_ff;

   // valid bit: cleared by reset, table starts empty
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= entry_in.valid;
      end
   end

   // payload moves with the valid bit, no reset
   always_ff @(posedge clock) begin
      if (shift) begin
         node_id_ff <= entry_in.node_id;
         address_ff <= entry_in.address;
         alive_ff   <= entry_in.alive;
      end
   end

   assign entry_out = '{valid: valid_ff, node_id: node_id_ff,
                        address: address_ff, alive: alive_ff};

endmodule

[hw/rtl/hnt_ctrl.sv]
// Sequencer of the neighbor table: item checks, head-of-ring edit, result register.
// Depends on hnt_pkg; drives the shift of the hnt_cell ring.
`timescale 1ns / 1ps

module hnt_ctrl #(
   parameter int INTERFACES              = 4,
   parameter int NEIGHBORS_PER_INTERFACE = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  hnt_pkg::cfg_type    cfg,
   // request side
   input  logic                req_valid,
   output logic                req_ready,
   input  hnt_pkg::item_type   req_item,
   // ring side
   input  hnt_pkg::entry_type  head_in,
   output hnt_pkg::entry_type  tail_out,
   output logic                shift,
   // result side
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hnt_pkg::result_type rsp_result
);
   import hnt_pkg::*;

   localparam int TOTAL = INTERFACES * NEIGHBORS_PER_INTERFACE;
   localparam int POS_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int SUB_W = (NEIGHBORS_PER_INTERFACE > 1) ? $clog2(NEIGHBORS_PER_INTERFACE) : 1;
   localparam int IFC_W = (INTERFACES > 1) ? $clog2(INTERFACES) : 1;
   localparam logic [POS_W-1:0]     POS_LAST   = POS_W'(TOTAL - 1);
   localparam logic [SUB_W-1:0]     SUB_LAST   = SUB_W'(NEIGHBORS_PER_INTERFACE - 1);
   localparam logic [IFACE_W:0]     IFACE_LIM  = (IFACE_W + 1)'(INTERFACES);
   localparam logic [REMOVED_W-1:0] REMOVED_MAX = '1;

   fsm_type state_ff, state_in;

   item_type             item_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [SUB_W-1:0]     sub_ff;
   logic [IFC_W-1:0]     ifc_ff;
   logic                 known_ff;
   logic                 free_found_ff;
   logic [POS_W-1:0]     free_pos_ff;
   logic [REMOVED_W-1:0] removed_ff;
   status_type           status_ff;
   logic                 rsp_valid_ff;
   result_type           rsp_result_ff;

   logic       accept;
   logic       early_done;
   status_type early_status;
   logic       last_step;
   logic       own;
   logic       id_match;
   logic       hit_known;
   logic       hit_free;
   logic       hit_remove;
   logic       known_now;
   logic       free_now;
   logic       out_free;

   assign accept    = req_valid && req_ready;
   assign last_step = (pos_ff == POS_LAST);
   assign own       = (IFACE_W'(ifc_ff) == item_ff.iface_index);
   assign id_match  = (head_in.node_id == item_ff.peer_id);
   assign known_now = known_ff || hit_known;
   assign free_now  = free_found_ff || hit_free;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // checks that settle a hello without walking the table
   always_comb begin
      early_done   = 1'b0;
      early_status = ST_REFRESHED;
      if (req_item.kind == KIND_HELLO) begin
         if (req_item.hello_interval != cfg.hello_interval) begin
            early_done   = 1'b1;
            early_status = ST_BAD_INTERVAL;
         end else if ({1'b0, req_item.iface_index} >= IFACE_LIM) begin
            early_done   = 1'b1;
            early_status = ST_BAD_MASK;
         end else if (req_item.hello_mask != cfg.mask[req_item.iface_index]) begin
            early_done   = 1'b1;
            early_status = ST_BAD_MASK;
         end else if (req_item.peer_id == '0) begin
            early_done   = 1'b1;
            early_status = ST_REFRESHED;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = early_done ? S_REPLY : S_SCAN;
            end
         end
         S_SCAN: begin
            if (last_step) begin
               if (item_ff.kind == KIND_HELLO && !known_now && free_now) begin
                  state_in = S_INSERT;
               end else begin
                  state_in = S_REPLY;
               end
            end
         end
         S_INSERT: begin
            if (last_step) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs: ring shift and the edit of the entry passing the head
   always_comb begin
      req_ready  = 1'b0;
      shift      = 1'b0;
      tail_out   = head_in;
      hit_known  = 1'b0;
      hit_free   = 1'b0;
      hit_remove = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_SCAN: begin
            shift = 1'b1;
            if (item_ff.kind == KIND_TICK) begin
               if (head_in.valid) begin
                  if (head_in.alive == '0) begin
                     tail_out.valid = 1'b0;
                     hit_remove     = 1'b1;
                  end else begin
                     tail_out.alive = head_in.alive - 1'b1;
                  end
               end
            end else if (head_in.valid && id_match) begin
               tail_out.alive = cfg.timeout;
               if (own) begin
                  tail_out.address = item_ff.neighbor_addr;
                  hit_known        = 1'b1;
               end
            end else if (own && !head_in.valid) begin
               hit_free = 1'b1;
            end
         end
         S_INSERT: begin
            shift = 1'b1;
            if (pos_ff == free_pos_ff) begin
               tail_out = '{valid: 1'b1, node_id: item_ff.peer_id,
                            address: item_ff.neighbor_addr, alive: cfg.timeout};
            end
         end
         S_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         known_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            known_ff      <= 1'b0;
            free_found_ff <= 1'b0;
         end else if (state_ff == S_SCAN) begin
            known_ff      <= known_now;
            free_found_ff <= free_now;
         end
         if (state_ff == S_REPLY && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item, walk counters and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff    <= req_item;
         pos_ff     <= '0;
         sub_ff     <= '0;
         ifc_ff     <= '0;
         removed_ff <= '0;
         status_ff  <= early_status;
      end else if (shift) begin
         if (last_step) begin
            pos_ff <= '0;
            sub_ff <= '0;
            ifc_ff <= '0;
         end else begin
            pos_ff <= pos_ff + 1'b1;
            if (sub_ff == SUB_LAST) begin
               sub_ff <= '0;
               ifc_ff <= ifc_ff + 1'b1;
            end else begin
               sub_ff <= sub_ff + 1'b1;
            end
         end
      end
      // first free slot of the receiving interface
      if (state_ff == S_SCAN && hit_free && !free_found_ff) begin
         free_pos_ff <= pos_ff;
      end
      if (hit_remove && removed_ff != REMOVED_MAX) begin
         removed_ff <= removed_ff + 1'b1;
      end
      // outcome of a full walk
      if (state_ff == S_SCAN && last_step) begin
         if (item_ff.kind == KIND_TICK) begin
            status_ff <= ST_TICK;
         end else if (known_now) begin
            status_ff <= ST_REFRESHED;
         end else if (free_now) begin
            status_ff <= ST_ADDED;
         end else begin
            status_ff <= ST_FULL;
         end
      end
      if (state_ff == S_REPLY && out_free) begin
         rsp_result_ff <= '{status: status_ff, removed_count: removed_ff};
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

[hw/rtl/hello_neighbor_table.sv]
// Top level of the hello neighbor table: ports, configuration registers, cell ring.
// Depends on hnt_pkg, hnt_cell and hnt_ctrl.
`timescale 1ns / 1ps

// Neighbor table for hello-based discovery. Each request is a received hello
// (tuser 0) or an aging tick (tuser 1) and yields exactly one response. The
// entries sit in a ring of INTERFACES * NEIGHBORS_PER_INTERFACE cells that
// rotates by one cell per cycle while the table is walked; the entry at the
// head of the ring is checked and edited on its way back to the tail, so one
// full turn visits every entry once. A tick or a hello that refreshes or finds
// the table full takes one turn between the accept and reply states; a hello
// that adds an entry takes a second turn to write the free slot; a hello
// rejected on interval, mask or with router id zero is answered without a turn.
// A new request is taken while the previous response still waits in the
// output register. Configuration writes are accepted in every cycle and must
// only be issued while the block is idle.

module hello_neighbor_table #(
   parameter int INTERFACES              = 4,
   parameter int NEIGHBORS_PER_INTERFACE = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: iface_index[1:0], peer_id[33:2], neighbor_addr[65:34],
   //        hello_interval[81:66], hello_mask[113:82], zero[119:114]
   input  logic [hnt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: kind
   input  logic                               req_tuser,
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: removed_count[5:0], zero[7:6]
   output logic [hnt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: status[2:0]
   output logic [2:0]                         rsp_tuser,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hnt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hnt_pkg::CSR_DATA_W-1:0]     csr_data
);
   import hnt_pkg::*;

   localparam int TOTAL = INTERFACES * NEIGHBORS_PER_INTERFACE;

   cfg_type    cfg_ff;
   item_type   req_item;
   result_type rsp_result;
   entry_type  ring_q [TOTAL];
   entry_type  tail_in;
   logic       shift;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hello_interval <= HELLO_INTERVAL_RST;
         cfg_ff.timeout        <= TIMEOUT_RST;
         cfg_ff.mask           <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_HELLO_INTERVAL: cfg_ff.hello_interval <= csr_data[IVL_W-1:0];
            REG_TIMEOUT:        cfg_ff.timeout        <= csr_data[ALIVE_W-1:0];
            REG_MASK_IF0:       cfg_ff.mask[0]        <= csr_data[MASK_W-1:0];
            REG_MASK_IF1:       cfg_ff.mask[1]        <= csr_data[MASK_W-1:0];
            REG_MASK_IF2:       cfg_ff.mask[2]        <= csr_data[MASK_W-1:0];
            REG_MASK_IF3:       cfg_ff.mask[3]        <= csr_data[MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // unpack the request
   assign req_item = '{kind:           req_tuser,
                       iface_index:    req_tdata[1:0],
                       peer_id:        req_tdata[33:2],
                       neighbor_addr:  req_tdata[65:34],
                       hello_interval: req_tdata[81:66],
                       hello_mask:     req_tdata[113:82]};

   hnt_ctrl #(
      .INTERFACES              (INTERFACES),
      .NEIGHBORS_PER_INTERFACE (NEIGHBORS_PER_INTERFACE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .head_in    (ring_q[0]),
      .tail_out   (tail_in),
      .shift      (shift),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   // ring of cells: each takes its neighbor's entry, the last takes the edited head
   for (genvar k = 0; k < TOTAL; k++) begin : g_ring
      entry_type cell_in;
      if (k == TOTAL - 1) begin : g_tail
         assign cell_in = tail_in;
      end else begin : g_mid
         assign cell_in = ring_q[k + 1];
      end
      hnt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .entry_in  (cell_in),
         .entry_out (ring_q[k])
      );
   end

   // pack the response
   assign rsp_tdata = {2'b00, rsp_result.removed_count};
   assign rsp_tuser = rsp_result.status;

endmodule
